>>> rtl/quadrature_knob_decoder_defines.svh
// Assertion macros used by the knob decoder top level.
`ifndef QUADRATURE_KNOB_DECODER_DEFINES_SVH
`define QUADRATURE_KNOB_DECODER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define QKD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define QKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/qkd_pkg.sv
// Types and constants for the quadrature knob decoder.
package qkd_pkg;

  localparam int CHAN_W = 2;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 8;

  localparam logic [CNT_W-1:0] SETTLE_RESET = 8'd2;
  // Bit 0 is A, bit 1 is B; both high is the idle detent.
  localparam logic [1:0] PINS_IDLE = 2'b11;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_CW   = 2'd1;
  localparam logic [1:0] STEP_ACW  = 2'd2;

  typedef enum logic [1:0] {
    DIR_STOP,
    DIR_CW,
    DIR_ACW,
    DIR_WAIT
  } dir_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              pin_a;
    logic              pin_b;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [1:0]              step_event;
    logic                    settling;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       prev_pins;
    dir_t             dir;
    logic [POS_W-1:0] position;
  } chan_entry_t;

  localparam int ENTRY_W = $bits(chan_entry_t);

  localparam chan_entry_t ENTRY_RESET = '{prev_pins: PINS_IDLE, dir: DIR_STOP, position: '0};

endpackage

>>> rtl/qkd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qkd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/qkd_step.sv
// Per-tick update: shared settle countdown and the direction machine of one channel.
module qkd_step (
  input  logic [qkd_pkg::CNT_W-1:0] cnt,
  input  logic [qkd_pkg::CNT_W-1:0] settle_ticks,
  input  logic [1:0]                pins,
  input  logic                      in_range,
  input  qkd_pkg::chan_entry_t      entry,
  output logic [qkd_pkg::CNT_W-1:0] cnt_next,
  output qkd_pkg::chan_entry_t      entry_next,
  output qkd_pkg::out_item_t        result
);
  import qkd_pkg::*;

  logic             a, b, a_old, b_old;
  logic             run;
  dir_t             dir_start, dir_next;
  logic [1:0]       ev;
  logic [POS_W-1:0] pos_next;

  assign a     = pins[0];
  assign b     = pins[1];
  assign a_old = entry.prev_pins[0];
  assign b_old = entry.prev_pins[1];
  assign run   = in_range && (cnt == CNT_W'(1));

  // Idle pins force the machine back to stop before it is evaluated.
  assign dir_start = (a && b) ? DIR_STOP : entry.dir;

  always_comb begin
    dir_next = dir_start;
    unique case (dir_start)
      DIR_STOP: begin
        if (!a && a_old && b) begin
          dir_next = DIR_CW;
        end else if (!b && b_old && a) begin
          dir_next = DIR_ACW;
        end
      end
      DIR_CW: begin
        if (a && !a_old && !b) dir_next = DIR_WAIT;
      end
      DIR_ACW: begin
        if (b && !b_old && !a) dir_next = DIR_WAIT;
      end
      DIR_WAIT: begin
        if (a && b) dir_next = DIR_STOP;
      end
      default: dir_next = DIR_STOP;
    endcase
  end

  always_comb begin
    ev       = STEP_NONE;
    pos_next = entry.position;
    unique case (dir_start)
      DIR_CW: begin
        if (a && !a_old && !b) begin
          ev       = STEP_CW;
          pos_next = entry.position + POS_W'(1);
        end
      end
      DIR_ACW: begin
        if (b && !b_old && !a) begin
          ev       = STEP_ACW;
          pos_next = entry.position - POS_W'(1);
        end
      end
      DIR_STOP, DIR_WAIT: begin
        ev = STEP_NONE;
      end
      default: ev = STEP_NONE;
    endcase
  end

  always_comb begin
    cnt_next   = cnt;
    entry_next = entry;
    if (in_range) begin
      if (cnt == '0) begin
        if (pins != entry.prev_pins) cnt_next = settle_ticks;
      end else if (cnt > CNT_W'(1)) begin
        cnt_next = cnt - CNT_W'(1);
      end else begin
        cnt_next   = '0;
        entry_next = '{prev_pins: pins, dir: dir_next, position: pos_next};
      end
    end
  end

  always_comb begin
    result.position   = in_range ? signed'(entry_next.position) : '0;
    result.step_event = run ? ev : STEP_NONE;
    result.settling   = (cnt_next != '0);
  end

endmodule

>>> rtl/quadrature_knob_decoder.sv
// Top level of the debounced multi-channel quadrature knob decoder.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data   (channel, pin_a, pin_b)
// out      output     out_valid / out_ready  out_data  (position, step_event, settling)
// cfg      input      cfg_valid / cfg_ready  cfg_data  (settle_ticks)
//
// One transaction per cycle while out_ready is high; stage 1 holds the item, out_data its result.
// Per-channel state sits in one RAM read at acceptance and written back as the item leaves;
// a write to the entry being read is forwarded, and the shared settle counter is a register.
// Reset clears the per-channel valid bits at once, so an entry never written reads as idle.
// A stalled output holds the result register; the input stalls only when both stages are full.
`include "quadrature_knob_decoder_defines.svh"

module quadrature_knob_decoder #(
  parameter int CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qkd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qkd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import qkd_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = IDX_W + CHAN_W;

  logic [CNT_W-1:0] settle_ticks;
  logic [CNT_W-1:0] settle_cnt;
  logic [CNT_W-1:0] settle_cnt_next;

  logic             in_fire, s1_fire;
  logic [EXT_W-1:0] ch_ext;
  logic [IDX_W-1:0] idx;
  logic             in_range;

  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [1:0]       s1_pins;
  logic             s1_in_range;
  logic             s1_ok;
  logic             fwd_hit;
  chan_entry_t      fwd_data;

  logic [CHANNELS-1:0] entry_ok;
  logic                wr_en;
  logic [ENTRY_W-1:0]  ram_rdata;
  chan_entry_t         cur_entry;
  chan_entry_t         entry_next;
  out_item_t           result;

  assign ch_ext   = {{IDX_W{1'b0}}, in_data.channel};
  assign idx      = ch_ext[IDX_W-1:0];
  assign in_range = ch_ext < EXT_W'(CHANNELS);

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_fire && s1_in_range;
  assign cfg_ready = 1'b1;

  qkd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_idx),
    .wdata(entry_next),
    .re   (in_fire),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (fwd_hit) begin
      cur_entry = fwd_data;
    end else if (s1_ok) begin
      cur_entry = chan_entry_t'(ram_rdata);
    end else begin
      cur_entry = ENTRY_RESET;
    end
  end

  qkd_step u_step (
    .cnt         (settle_cnt),
    .settle_ticks(settle_ticks),
    .pins        (s1_pins),
    .in_range    (s1_in_range),
    .entry       (cur_entry),
    .cnt_next    (settle_cnt_next),
    .entry_next  (entry_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      settle_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      settle_cnt <= '0;
      entry_ok   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        settle_cnt <= settle_cnt_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        entry_ok[s1_idx] <= 1'b1;
      end
    end
  end

  // Capture the item and, if the entry is being written back this cycle, its new value.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx      <= idx;
      s1_pins     <= {in_data.pin_b, in_data.pin_a};
      s1_in_range <= in_range;
      s1_ok       <= in_range && entry_ok[idx];
      fwd_hit     <= wr_en && (s1_idx == idx);
      fwd_data    <= entry_next;
    end
    if (s1_fire) begin
      out_data <= result;
    end
  end

  `QKD_ASSERT_NOW(a_step_code, clk, rst, out_valid, out_data.step_event != 2'd3, "bad step code")

  `QKD_ASSERT_NOW(a_step_on_final, clk, rst, s1_fire && (result.step_event != STEP_NONE),
                  settle_cnt == CNT_W'(1), "step counted outside final settle tick")

  `QKD_ASSERT_NEXT(a_cnt_hold, clk, rst, !s1_fire, settle_cnt == $past(settle_cnt),
                   "settle counter moved without a transaction")

  `QKD_ASSERT_NEXT(a_accept_fills, clk, rst, in_fire, s1_valid, "accepted item lost")

  `QKD_ASSERT_NEXT(a_fire_shows, clk, rst, s1_fire, out_valid, "result not presented")

endmodule

>>> test/tb_quadrature_knob_decoder.sv
// Self-checking testbench for the quadrature knob decoder: driven ticks, predicted readings.
`timescale 1ns / 1ps

module tb_quadrature_knob_decoder;
  import qkd_pkg::*;

  localparam int NUM_KNOBS = 4;

  // Tracks every knob as the decoder should and queues the reading due for each tick.
  class knob_tracker;
    logic [7:0]       settle_ticks;
    logic [1:0]       latched[NUM_KNOBS];
    logic [1:0]       previous[NUM_KNOBS];
    dir_t             direction[NUM_KNOBS];
    logic [POS_W-1:0] count[NUM_KNOBS];
    logic [7:0]       settle_left;
    out_item_t        expected_readings[$];
    int               mismatches;

    function void clear();
      settle_ticks = SETTLE_RESET;
      settle_left = '0;
      mismatches = 0;
      for (int i = 0; i < NUM_KNOBS; i++) begin
        latched[i] = PINS_IDLE;
        previous[i] = PINS_IDLE;
        direction[i] = DIR_STOP;
        count[i] = '0;
      end
    endfunction

    function logic [1:0] decode_motion(int ch);
      logic       a, b, a_old, b_old;
      logic [1:0] step;
      a = latched[ch][0];
      b = latched[ch][1];
      a_old = previous[ch][0];
      b_old = previous[ch][1];
      step = STEP_NONE;
      // both pins high is the detent rest: drop any half-finished turn
      if (a && b) direction[ch] = DIR_STOP;
      case (direction[ch])
        DIR_STOP: begin
          if (!a && a_old && b) direction[ch] = DIR_CW;
          else if (!b && b_old && a) direction[ch] = DIR_ACW;
        end
        DIR_CW: begin
          if (a && !a_old && !b) begin
            count[ch] = count[ch] + 8'd1;
            direction[ch] = DIR_WAIT;
            step = STEP_CW;
          end
        end
        DIR_ACW: begin
          if (b && !b_old && !a) begin
            count[ch] = count[ch] - 8'd1;
            direction[ch] = DIR_WAIT;
            step = STEP_ACW;
          end
        end
        default: begin
          if (a && b) direction[ch] = DIR_STOP;
        end
      endcase
      previous[ch] = latched[ch];
      return step;
    endfunction

    function void note_tick(in_item_t item);
      int         ch;
      logic [1:0] pins;
      out_item_t  due;
      ch = item.channel;
      pins = {item.pin_b, item.pin_a};
      due.step_event = STEP_NONE;
      if (settle_left == 0) begin
        latched[ch] = pins;
        if (latched[ch] != previous[ch]) settle_left = settle_ticks;
      end else if (settle_left > 1) begin
        settle_left = settle_left - 8'd1;
      end else begin
        // final tick of the countdown: resample and run whichever knob it names
        settle_left = '0;
        latched[ch] = pins;
        due.step_event = decode_motion(ch);
      end
      due.position = count[ch];
      due.settling = (settle_left != 0);
      expected_readings.push_back(due);
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: reading with none expected: position %0d step %0d settling %0b",
                 $time, got.position, got.step_event, got.settling);
        mismatches++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.position !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time, want.position, got.position);
        mismatches++;
      end
      if (got.step_event !== want.step_event) begin
        $display("%0t: step_event expected %0d actual %0d", $time, want.step_event,
                 got.step_event);
        mismatches++;
      end
      if (got.settling !== want.settling) begin
        $display("%0t: settling expected %0b actual %0b", $time, want.settling, got.settling);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  knob_tracker tracker;
  bit          allow_idle = 1'b1;
  bit          hold_output = 1'b0;
  int          ticks_sent = 0;

  always #4 clk = ~clk;

  quadrature_knob_decoder #(.CHANNELS(NUM_KNOBS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Reading side: check each transaction, then choose the next ready level.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) tracker.check_reading(out_data);
      if (stall_left == 0) begin
        if (hold_output) begin
          hold_output = 1'b0;
          stall_left = 40;
        end else if (allow_idle && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 4);
        end
      end
      if (!rst && stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        if (stall_left != 0) stall_left--;
      end
    end
  end

  task automatic send_tick(input logic [1:0] ch, input logic [1:0] pins);
    in_item_t item;
    item.channel = ch;
    item.pin_a = pins[0];
    item.pin_b = pins[1];
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_tick(item);
    ticks_sent++;
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic noise_ticks(input int n);
    repeat (n) send_tick(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  // One detent, each pin phase held for up to 'hold' ticks; ragged cuts phases short.
  task automatic turn_detent(input logic [1:0] ch, input bit cw, input int hold,
                             input bit shortcut, input bit ragged);
    logic [1:0] phases[$];
    int         n;
    // pins are {B, A}
    if (cw && shortcut) phases = '{2'b10, 2'b01, 2'b11};
    else if (cw) phases = '{2'b10, 2'b00, 2'b01, 2'b11};
    else if (shortcut) phases = '{2'b01, 2'b10, 2'b11};
    else phases = '{2'b01, 2'b00, 2'b10, 2'b11};
    foreach (phases[i]) begin
      n = ragged ? $urandom_range(1, hold) : hold;
      repeat (n) send_tick(ch, phases[i]);
      if (ragged && $urandom_range(0, 2) == 0) noise_ticks(1);
    end
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settle(input logic [7:0] value);
    drain_readings();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.settle_ticks = value;
  endtask

  task automatic random_knobs(input logic [7:0] settle, input int budget);
    int start, hold, pick;
    start = ticks_sent;
    hold = settle + 1;
    while (ticks_sent - start < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        turn_detent(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    hold + $urandom_range(0, 1), 1'($urandom_range(0, 1)), 1'b0);
      end else if (pick < 8) begin
        turn_detent(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), hold,
                    1'($urandom_range(0, 1)), 1'b1);
      end else begin
        noise_ticks($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    tracker = new();
    tracker.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // settle register at its reset value: three ticks per pin phase
    turn_detent(2'd0, 1'b1, 3, 1'b1, 1'b0);
    turn_detent(2'd3, 1'b0, 3, 1'b1, 1'b0);
    repeat (3) send_tick(2'd1, 2'b10);
    repeat (3) send_tick(2'd1, 2'b11);

    // spin one knob back past zero so its count wraps below it
    write_settle(8'd1);
    repeat (12) turn_detent(2'd0, 1'b0, 2, 1'b1, 1'b0);

    write_settle(8'd3);
    random_knobs(8'd3, 50);
    // hold the reading side off while ticks keep coming, then wait for the backlog
    hold_output = 1'b1;
    allow_idle = 1'b0;
    noise_ticks(24);
    allow_idle = 1'b1;
    drain_readings();
    random_knobs(8'd3, 30);

    write_settle(8'd0);
    random_knobs(8'd0, 40);

    write_settle(8'd2);
    random_knobs(8'd2, 40);

    // long countdown shared across every knob
    write_settle(8'd60);
    send_tick(2'd1, 2'b10);
    send_tick(2'd1, 2'b01);
    noise_ticks(70);

    write_settle(8'd4);
    random_knobs(8'd4, 40);

    write_settle(8'd1);
    allow_idle = 1'b0;
    random_knobs(8'd1, 40);
    in_valid <= 1'b0;

    for (int waited = 0; waited < 2000 && tracker.pending() != 0; waited++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_quadrature_knob_decoder: PASS");
    end else begin
      if (tracker.pending() != 0) $display("%0t: %0d readings never arrived", $time,
                                           tracker.pending());
      $display("tb_quadrature_knob_decoder: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_quadrature_knob_decoder: FAIL");
    $finish;
  end

endmodule
